// ===== rtl/abu_pkg.sv =====
// Shared types, constants and helpers for the alpha bounding box union block.
package abu_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int DIM_W    = $clog2(MAX_DIM);
   localparam int SIZE_W   = DIM_W + 1;
   localparam int ALPHA_W  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PIXELS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 2'd2;

   localparam logic [SIZE_W-1:0]  RST_ROW_PIXELS      = SIZE_W'(640);
   localparam logic [SIZE_W-1:0]  RST_FRAME_ROWS      = SIZE_W'(480);
   localparam logic [ALPHA_W-1:0] RST_ALPHA_THRESHOLD = ALPHA_W'(1);

   typedef struct packed {
      logic [SIZE_W-1:0]  row_pixels;
      logic [SIZE_W-1:0]  frame_rows;
      logic [ALPHA_W-1:0] alpha_threshold;
   } cfg_type;

   typedef struct packed {
      logic              last;
      logic              empty;
      logic [DIM_W-1:0]  left;
      logic [DIM_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } frame_box_type;

   typedef struct packed {
      logic [DIM_W-1:0]  left;
      logic [DIM_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } union_box_type;

   // Index of the last pixel along a dimension; 0 acts as 1, large values saturate.
   function automatic logic [DIM_W-1:0] dim_last(input logic [SIZE_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > SIZE_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM - 1);
      end else begin
         r = DIM_W'(v - SIZE_W'(1));
      end
      return r;
   endfunction

endpackage

// ===== rtl/abu_if.sv =====
// Channel interfaces: pixel input, box result and register write.
interface abu_req_if;
   logic                         valid;
   logic                         ready;
   logic [abu_pkg::ALPHA_W-1:0]  alpha;
   logic                         new_group;
   modport source (output valid, output alpha, output new_group, input ready);
   modport sink   (input valid, input alpha, input new_group, output ready);
endinterface

interface abu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_empty;
   logic [abu_pkg::DIM_W-1:0]   frame_left;
   logic [abu_pkg::DIM_W-1:0]   frame_top;
   logic [abu_pkg::SIZE_W-1:0]  frame_box_width;
   logic [abu_pkg::SIZE_W-1:0]  frame_box_height;
   logic [abu_pkg::DIM_W-1:0]   union_left;
   logic [abu_pkg::DIM_W-1:0]   union_top;
   logic [abu_pkg::SIZE_W-1:0]  union_width;
   logic [abu_pkg::SIZE_W-1:0]  union_height;
   modport source (output valid, output frame_empty, output frame_left, output frame_top,
                   output frame_box_width, output frame_box_height, output union_left,
                   output union_top, output union_width, output union_height,
                   input ready);
   modport sink   (input valid, input frame_empty, input frame_left, input frame_top,
                   input frame_box_width, input frame_box_height, input union_left,
                   input union_top, input union_width, input union_height,
                   output ready);
endinterface

interface abu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [abu_pkg::CSR_IDX_W-1:0]    index;
   logic [abu_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/abu_scan.sv =====
// Raster position counters and per-frame extent of visible pixels.
module abu_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [abu_pkg::ALPHA_W-1:0]   alpha,
   input  abu_pkg::cfg_type              cfg,
   output abu_pkg::frame_box_type        frame
);
   import abu_pkg::*;

   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [DIM_W-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic             seen_ff, seen_in;
   logic [DIM_W-1:0] mnc, mxc, mnr, mxr;
   logic             seen_nx, visible, row_end, frame_end;

   always_comb begin
      visible   = alpha >= cfg.alpha_threshold;
      row_end   = col_ff >= dim_last(cfg.row_pixels);
      frame_end = row_end && (row_ff >= dim_last(cfg.frame_rows));
      mnc = min_col_ff;
      mxc = max_col_ff;
      mnr = min_row_ff;
      mxr = max_row_ff;
      seen_nx = seen_ff;
      if (visible) begin
         seen_nx = 1'b1;
         if (!seen_ff) begin
            mnc = col_ff;
            mxc = col_ff;
            mnr = row_ff;
            mxr = row_ff;
         end else begin
            if (col_ff < min_col_ff) mnc = col_ff;
            if (col_ff > max_col_ff) mxc = col_ff;
            if (row_ff < min_row_ff) mnr = row_ff;
            if (row_ff > max_row_ff) mxr = row_ff;
         end
      end

      frame.last   = frame_end;
      frame.empty  = !seen_nx;
      frame.left   = seen_nx ? mnc : '0;
      frame.top    = seen_nx ? mnr : '0;
      frame.width  = seen_nx ? ({1'b0, mxc} - {1'b0, mnc} + SIZE_W'(1)) : '0;
      frame.height = seen_nx ? ({1'b0, mxr} - {1'b0, mnr} + SIZE_W'(1)) : '0;

      col_in     = col_ff;
      row_in     = row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      seen_in    = seen_ff;
      if (fire) begin
         if (frame_end) begin
            col_in     = '0;
            row_in     = '0;
            min_col_in = '0;
            max_col_in = '0;
            min_row_in = '0;
            max_row_in = '0;
            seen_in    = 1'b0;
         end else begin
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + DIM_W'(1);
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
            min_col_in = mnc;
            max_col_in = mxc;
            min_row_in = mnr;
            max_row_in = mxr;
            seen_in    = seen_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         min_col_ff <= '0;
         max_col_ff <= '0;
         min_row_ff <= '0;
         max_row_ff <= '0;
         seen_ff    <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// ===== rtl/abu_union.sv =====
// Running union of non-empty frame boxes over a group.
module abu_union (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    new_group,
   input  abu_pkg::frame_box_type  frame,
   output abu_pkg::union_box_type  union_box
);
   import abu_pkg::*;

   localparam int EDGE_W = SIZE_W + 1;

   union_box_type acc_ff, acc_in, base, nx;
   logic [EDGE_W-1:0] fr_right, fr_bottom, ac_right, ac_bottom, right, bottom;
   logic [DIM_W-1:0]  left, top;

   always_comb begin
      base = new_group ? '0 : acc_ff;
      fr_right  = EDGE_W'(frame.left) + EDGE_W'(frame.width);
      fr_bottom = EDGE_W'(frame.top) + EDGE_W'(frame.height);
      ac_right  = EDGE_W'(base.left) + EDGE_W'(base.width);
      ac_bottom = EDGE_W'(base.top) + EDGE_W'(base.height);
      right  = (ac_right > fr_right) ? ac_right : fr_right;
      bottom = (ac_bottom > fr_bottom) ? ac_bottom : fr_bottom;
      left   = (frame.left < base.left) ? frame.left : base.left;
      top    = (frame.top < base.top) ? frame.top : base.top;

      nx = base;
      if (frame.last && !frame.empty) begin
         if (base.width != '0 && base.height != '0) begin
            nx.left   = left;
            nx.top    = top;
            nx.width  = SIZE_W'(right - EDGE_W'(left));
            nx.height = SIZE_W'(bottom - EDGE_W'(top));
         end else begin
            nx.left   = frame.left;
            nx.top    = frame.top;
            nx.width  = frame.width;
            nx.height = frame.height;
         end
      end
      acc_in    = fire ? nx : acc_ff;
      union_box = nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/alpha_bounding_box_union.sv =====
// Top level: pixel input register, scan and union logic, result register.
// Usage:
//   req_ch carries one pixel per transfer (alpha, new_group) in raster order,
//   row by row, for frames of the configured row length and row count.
//   rsp_ch carries one result per frame, at the frame's last pixel: the
//   frame's box (or frame_empty) and the union of boxes since new_group.
//   csr_ch writes the row length (0), row count (1) and alpha threshold (2);
//   it is always ready and must be used only while the block is idle.
// Timing:
//   A pixel is taken into the input register and processed from there, unless it
//   ends a frame while the result register is still full; a frame-ending pixel
//   loads the result register when processed, which raises rsp_ch.valid. Sustained rate
//   is one pixel per cycle, unless a frame-ending pixel waits for the result register.
// Stalls:
//   While a result waits in the result register and rsp_ch.ready is low,
//   pixels that do not end a frame keep flowing; the next frame-ending pixel
//   waits in the input register and req_ch.ready drops until it can move.
// Reset:
//   Synchronous reset empties both registers, zeroes counters and union and
//   restores the register defaults (640 x 480, threshold 1).
module alpha_bounding_box_union (
   input logic        clock,
   input logic        reset,
   abu_req_if.sink    req_ch,
   abu_rsp_if.source  rsp_ch,
   abu_csr_if.sink    csr_ch
);
   import abu_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               in_valid_ff, in_valid_in;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               group_ff;
   logic               out_valid_ff, out_valid_in;
   frame_box_type      frame;
   union_box_type      union_box;
   frame_box_type      frame_ff;
   union_box_type      union_ff;
   logic               proc_fire, out_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ROW_PIXELS:      cfg_in.row_pixels      = csr_ch.data;
            CSR_FRAME_ROWS:      cfg_in.frame_rows      = csr_ch.data;
            CSR_ALPHA_THRESHOLD: cfg_in.alpha_threshold = csr_ch.data[ALPHA_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   abu_scan u_scan (
      .clock (clock),
      .reset (reset),
      .fire  (proc_fire),
      .alpha (alpha_ff),
      .cfg   (cfg_ff),
      .frame (frame)
   );

   abu_union u_union (
      .clock     (clock),
      .reset     (reset),
      .fire      (proc_fire),
      .new_group (group_ff),
      .frame     (frame),
      .union_box (union_box)
   );

   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      proc_fire    = in_valid_ff && (!frame.last || out_free);
      req_ch.ready = !in_valid_ff || proc_fire;
      in_valid_in  = req_ch.valid || (in_valid_ff && !proc_fire);
      out_valid_in = (proc_fire && frame.last) || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_pixels      <= RST_ROW_PIXELS;
         cfg_ff.frame_rows      <= RST_FRAME_ROWS;
         cfg_ff.alpha_threshold <= RST_ALPHA_THRESHOLD;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         alpha_ff <= req_ch.alpha;
         group_ff <= req_ch.new_group;
      end
      if (proc_fire && frame.last) begin
         frame_ff <= frame;
         union_ff <= union_box;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.frame_empty      = frame_ff.empty;
   assign rsp_ch.frame_left       = frame_ff.left;
   assign rsp_ch.frame_top        = frame_ff.top;
   assign rsp_ch.frame_box_width  = frame_ff.width;
   assign rsp_ch.frame_box_height = frame_ff.height;
   assign rsp_ch.union_left       = union_ff.left;
   assign rsp_ch.union_top        = union_ff.top;
   assign rsp_ch.union_width      = union_ff.width;
   assign rsp_ch.union_height     = union_ff.height;

endmodule

// ===== rtl/abu_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module abu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          frame_empty,
   input logic [abu_pkg::DIM_W-1:0]     frame_left,
   input logic [abu_pkg::DIM_W-1:0]     frame_top,
   input logic [abu_pkg::SIZE_W-1:0]    frame_box_width,
   input logic [abu_pkg::SIZE_W-1:0]    frame_box_height,
   input logic [abu_pkg::SIZE_W-1:0]    union_width,
   input logic [abu_pkg::SIZE_W-1:0]    union_height
);
   import abu_pkg::*;

   // Stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(frame_box_width) && $stable(union_width))
      else $error("result changed while stalled");

   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_empty |-> frame_left == '0 && frame_top == '0 &&
         frame_box_width == '0 && frame_box_height == '0)
      else $error("empty frame with a non-zero box");

   a_box_in_union: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_empty |-> frame_box_width != '0 && frame_box_height != '0 &&
         union_width >= frame_box_width && union_height >= frame_box_height)
      else $error("frame box not covered by union");

   a_union_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (union_width == '0) == (union_height == '0))
      else $error("union has one zero dimension");

endmodule

bind alpha_bounding_box_union abu_checker u_abu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .frame_empty      (rsp_ch.frame_empty),
   .frame_left       (rsp_ch.frame_left),
   .frame_top        (rsp_ch.frame_top),
   .frame_box_width  (rsp_ch.frame_box_width),
   .frame_box_height (rsp_ch.frame_box_height),
   .union_width      (rsp_ch.union_width),
   .union_height     (rsp_ch.union_height)
);

// ===== test/abu_box_checker.sv =====
// Watches the pixel, result and register channels and checks every frame result.
module abu_box_checker (
   input  logic clock,
   input  logic reset,
   abu_req_if   req_ch,
   abu_rsp_if   rsp_ch,
   abu_csr_if   csr_ch,
   output int   failures,
   output int   outstanding
);
   import abu_pkg::*;

   typedef struct packed {
      logic              empty;
      logic [DIM_W-1:0]  frame_left;
      logic [DIM_W-1:0]  frame_top;
      logic [SIZE_W-1:0] box_width;
      logic [SIZE_W-1:0] box_height;
      logic [DIM_W-1:0]  union_left;
      logic [DIM_W-1:0]  union_top;
      logic [SIZE_W-1:0] union_width;
      logic [SIZE_W-1:0] union_height;
   } box_result_type;

   cfg_type           cfg;
   logic [DIM_W-1:0]  col_pos, row_pos;
   logic [DIM_W-1:0]  min_col, min_row, max_col, max_row;
   logic [DIM_W-1:0]  acc_left, acc_top;
   logic [SIZE_W-1:0] acc_width, acc_height;
   logic              seen_visible;
   box_result_type    pending_boxes[$];
   int                fail_count = 0;
   int                pending_count = 0;

   assign failures    = fail_count;
   assign outstanding = pending_count;

   function automatic int span(input logic [SIZE_W-1:0] v);
      if (v == '0) return 1;
      if (v > SIZE_W'(MAX_DIM)) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void scan_pixel(input logic [ALPHA_W-1:0] a, input logic grp);
      int             w, h, right, bottom;
      logic           row_end, frame_end;
      box_result_type r;
      w = span(cfg.row_pixels);
      h = span(cfg.frame_rows);
      if (grp) begin
         acc_left   = '0;
         acc_top    = '0;
         acc_width  = '0;
         acc_height = '0;
      end
      if (a >= cfg.alpha_threshold) begin
         if (!seen_visible) begin
            min_col      = col_pos;
            max_col      = col_pos;
            min_row      = row_pos;
            max_row      = row_pos;
            seen_visible = 1'b1;
         end else begin
            if (col_pos < min_col) min_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos > max_row) max_row = row_pos;
         end
      end
      row_end   = int'(col_pos) >= w - 1;
      frame_end = row_end && (int'(row_pos) >= h - 1);
      if (!frame_end) begin
         if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + DIM_W'(1);
         end else begin
            col_pos = col_pos + DIM_W'(1);
         end
         return;
      end
      r = '0;
      r.empty = !seen_visible;
      if (seen_visible) begin
         r.frame_left = min_col;
         r.frame_top  = min_row;
         r.box_width  = SIZE_W'(int'(max_col) - int'(min_col) + 1);
         r.box_height = SIZE_W'(int'(max_row) - int'(min_row) + 1);
         if (acc_width != '0 && acc_height != '0) begin
            right  = int'(r.frame_left) + int'(r.box_width);
            bottom = int'(r.frame_top) + int'(r.box_height);
            if (int'(acc_left) + int'(acc_width) > right) right = int'(acc_left) + int'(acc_width);
            if (int'(acc_top) + int'(acc_height) > bottom) bottom = int'(acc_top) + int'(acc_height);
            if (r.frame_left < acc_left) acc_left = r.frame_left;
            if (r.frame_top < acc_top) acc_top = r.frame_top;
            acc_width  = SIZE_W'(right - int'(acc_left));
            acc_height = SIZE_W'(bottom - int'(acc_top));
         end else begin
            acc_left   = r.frame_left;
            acc_top    = r.frame_top;
            acc_width  = r.box_width;
            acc_height = r.box_height;
         end
      end
      r.union_left   = acc_left;
      r.union_top    = acc_top;
      r.union_width  = acc_width;
      r.union_height = acc_height;
      pending_boxes.push_back(r);
      col_pos      = '0;
      row_pos      = '0;
      seen_visible = 1'b0;
      min_col      = '0;
      min_row      = '0;
      max_col      = '0;
      max_row      = '0;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      box_result_type want;
      if (reset) begin
         cfg.row_pixels      = RST_ROW_PIXELS;
         cfg.frame_rows      = RST_FRAME_ROWS;
         cfg.alpha_threshold = RST_ALPHA_THRESHOLD;
         col_pos      = '0;
         row_pos      = '0;
         seen_visible = 1'b0;
         min_col      = '0;
         min_row      = '0;
         max_col      = '0;
         max_row      = '0;
         acc_left     = '0;
         acc_top      = '0;
         acc_width    = '0;
         acc_height   = '0;
         pending_boxes.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_ROW_PIXELS: begin
                  cfg.row_pixels = csr_ch.data;
               end
               CSR_FRAME_ROWS: begin
                  cfg.frame_rows = csr_ch.data;
               end
               CSR_ALPHA_THRESHOLD: begin
                  cfg.alpha_threshold = csr_ch.data[ALPHA_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) scan_pixel(req_ch.alpha, req_ch.new_group);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_boxes.size() == 0) begin
               $display("%0t: result transfer with no frame end pending", $time);
               fail_count++;
            end else begin
               want = pending_boxes.pop_front();
               check_field("frame_empty", int'(want.empty), int'(rsp_ch.frame_empty));
               check_field("frame_left", int'(want.frame_left), int'(rsp_ch.frame_left));
               check_field("frame_top", int'(want.frame_top), int'(rsp_ch.frame_top));
               check_field("frame_box_width", int'(want.box_width),
                           int'(rsp_ch.frame_box_width));
               check_field("frame_box_height", int'(want.box_height),
                           int'(rsp_ch.frame_box_height));
               check_field("union_left", int'(want.union_left), int'(rsp_ch.union_left));
               check_field("union_top", int'(want.union_top), int'(rsp_ch.union_top));
               check_field("union_width", int'(want.union_width), int'(rsp_ch.union_width));
               check_field("union_height", int'(want.union_height),
                           int'(rsp_ch.union_height));
            end
         end
      end
      pending_count = pending_boxes.size();
   end

endmodule

// ===== test/alpha_bounding_box_union_test.sv =====
// Top of the bounding box union testbench: clock, reset, pixel stimulus and verdict.
module alpha_bounding_box_union_test;
   import abu_pkg::*;

   typedef enum int {SHAPE_EMPTY, SHAPE_SPARSE, SHAPE_RECT, SHAPE_FULL} shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures, outstanding;
   int   pixels_sent = 0;
   int   cur_w, cur_h, cur_thr;

   abu_req_if req_ch ();
   abu_rsp_if rsp_ch ();
   abu_csr_if csr_ch ();

   alpha_bounding_box_union dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   abu_box_checker check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("alpha_bounding_box_union: mismatch");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 31);
      if (r < 18) return 0;
      if (r < 30) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int eff_dim(input int v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int pick_dim(input int top);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(top + 1, 2 * top);
      return $urandom_range(1, top);
   endfunction

   // result stall pattern
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clock);
         else repeat ($urandom_range(0, 12)) @(posedge clock);
         gap = idle_len();
         if (gap > 0) begin
            @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_dims(input int w, input int h);
      write_reg(CSR_ROW_PIXELS, w);
      write_reg(CSR_FRAME_ROWS, h);
      cur_w = eff_dim(w);
      cur_h = eff_dim(h);
   endtask

   // upper data bits are junk for the threshold register
   task automatic set_threshold(input int thr);
      write_reg(CSR_ALPHA_THRESHOLD, ($urandom_range(0, 31) << ALPHA_W) | thr);
      cur_thr = thr;
   endtask

   task automatic send_pixel(input int a, input bit grp, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.alpha     <= ALPHA_W'(a);
      req_ch.new_group <= grp;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
   endtask

   // hold off until every frame result has been taken, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame(input int shape_sel, input bit grp, input bit quiet,
                             input int count);
      int shape, x0, x1, y0, y1, col, row, a;
      bit vis;
      shape = (shape_sel < 0) ? $urandom_range(SHAPE_EMPTY, SHAPE_FULL) : shape_sel;
      x0 = $urandom_range(0, cur_w - 1);
      x1 = $urandom_range(x0, cur_w - 1);
      y0 = $urandom_range(0, cur_h - 1);
      y1 = $urandom_range(y0, cur_h - 1);
      for (int i = 0; i < count; i++) begin
         col = i % cur_w;
         row = i / cur_w;
         case (shape)
            SHAPE_EMPTY:  vis = 1'b0;
            SHAPE_SPARSE: vis = ($urandom_range(0, 15) == 0);
            SHAPE_RECT:   vis = (col >= x0 && col <= x1 && row >= y0 && row <= y1);
            default:      vis = 1'b1;
         endcase
         if (cur_thr == 0) vis = 1'b1;
         a = vis ? $urandom_range(cur_thr, 255) : $urandom_range(0, cur_thr - 1);
         send_pixel(a, (i == 0 && grp) || ($urandom_range(0, 63) == 0),
                    quiet ? 0 : idle_len());
      end
   endtask

   initial begin
      int p, wv, hv, frames;
      bit big_phase;
      req_ch.valid     <= 1'b0;
      req_ch.alpha     <= '0;
      req_ch.new_group <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_ROW_PIXELS;
      csr_ch.data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 3x2 frames: an empty one, then a full-extent box starting a group
      set_dims(3, 2);
      set_threshold(8'h80);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h7F, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 1);
      send_pixel(8'h7F, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h7F, 1'b1, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'hFF, 1'b0, 2);
      send_pixel(8'h80, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h10, 1'b0, 0);

      // zero sizes act as 1x1, zero threshold, new group on a last pixel
      settle();
      set_dims(0, 0);
      set_threshold(0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h00, 1'b1, 0);
      send_pixel(8'hFF, 1'b0, 0);

      // width shrinks while a frame is in progress
      settle();
      set_dims(4, 3);
      set_threshold(8'hFF);
      send_pixel(8'hFF, 1'b1, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'hFE, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'hFF, 1'b0, 0);
      settle();
      set_dims(2, 3);
      send_pixel(8'hFF, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);
      send_pixel(8'h00, 1'b0, 0);

      p = 0;
      while (pixels_sent < 500) begin
         settle();
         big_phase = 1'b1;
         case (p)
            1: begin
               wv = 8191;
               hv = 1;
            end
            3: begin
               wv = 1;
               hv = 4096;
            end
            5: begin
               wv = 4096;
               hv = 0;
            end
            default: begin
               wv = pick_dim(8);
               hv = pick_dim(6);
               big_phase = 1'b0;
            end
         endcase
         set_dims(wv, hv);
         if (big_phase || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
               0: set_threshold(0);
               1: set_threshold(255);
               default: set_threshold($urandom_range(1, 254));
            endcase
         end
         if (big_phase) begin
            // oversized frame, cut short by the next size change
            send_frame(($urandom_range(0, 1) == 1) ? SHAPE_FULL : SHAPE_RECT,
                       $urandom_range(0, 1) == 1, 1'b1, $urandom_range(1, 24));
         end else begin
            frames = $urandom_range(1, 4);
            repeat (frames) send_frame(-1, $urandom_range(0, 2) == 0,
                                       $urandom_range(0, 3) == 0, cur_w * cur_h);
            if ($urandom_range(0, 4) == 0)
               send_frame(-1, 1'b0, 1'b0, $urandom_range(1, cur_w * cur_h));
         end
         p++;
      end

      settle();
      if (failures == 0) begin
         $display("alpha_bounding_box_union: match");
      end else begin
         $display("alpha_bounding_box_union: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/abu_pkg.sv
rtl/abu_if.sv
rtl/abu_scan.sv
rtl/abu_union.sv
rtl/alpha_bounding_box_union.sv
rtl/abu_checker.sv
test/abu_box_checker.sv
test/alpha_bounding_box_union_test.sv
